// ===== hw/rtl/integer_to_ascii_formatter_assert.svh =====
// Assertion macros shared by the formatter RTL modules.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define I2A_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication outside reset.
`define I2A_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/i2a_pkg.sv =====
// Shared types, constants and helper functions of the integer to ASCII formatter.
package i2a_pkg;

    localparam int OP_W       = 3;
    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 7;
    localparam int POS_W      = 4;
    localparam int NIB_W      = 4;
    localparam int HEX_DIGITS = 16;
    localparam int DEC_DIGITS = 10;
    localparam int DEC_RADIX  = 10;
    localparam int DEC_MAG_W  = 32;
    localparam int DEC_TAB_W  = 34;
    localparam int QUEUE_DEPTH = 2;

    // format modes
    localparam logic [OP_W-1:0] OP_SDEC  = 3'd0;
    localparam logic [OP_W-1:0] OP_UDEC  = 3'd1;
    localparam logic [OP_W-1:0] OP_HEXL  = 3'd2;
    localparam logic [OP_W-1:0] OP_HEXU  = 3'd3;
    localparam logic [OP_W-1:0] OP_HEX64 = 3'd4;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 7'h66;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 7'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 7'h46;

    // One classified number, handed from front to back.
    typedef struct packed {
        logic               is_dec;
        logic               upper;
        logic               neg;
        logic [POS_W-1:0]   top_pos;
        logic [VALUE_W-1:0] mag;
    } job_t;

    // Row p holds k * 10^p for k = 0..9.
    typedef logic [DEC_DIGITS-1:0][DEC_RADIX-1:0][DEC_TAB_W-1:0] dec_tab_t;

    function automatic dec_tab_t dec_tab_build();
        dec_tab_t               tab;
        logic [DEC_TAB_W-1:0]   pw;
        pw = DEC_TAB_W'(1);
        for (int p = 0; p < DEC_DIGITS; p++)
        begin
            for (int k = 0; k < DEC_RADIX; k++)
            begin
                tab[p][k] = DEC_TAB_W'(k) * pw;
            end
            pw = pw * DEC_TAB_W'(DEC_RADIX);
        end
        return tab;
    endfunction

    localparam dec_tab_t DEC_TAB = dec_tab_build();

    function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] letter_base;
        letter_base = upper ? CH_UP_A : CH_LO_A;
        if (d < NIB_W'(DEC_RADIX))
        begin
            return CH_ZERO + CHAR_W'(d);
        end
        return letter_base + CHAR_W'(d - NIB_W'(DEC_RADIX));
    endfunction

endpackage

// ===== hw/rtl/i2a_front.sv =====
// Front end: accepts input words, classifies the mode and finds the leading digit.
module i2a_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [i2a_pkg::OP_W-1:0]      op,
    input  logic [i2a_pkg::VALUE_W-1:0]   value,
    output logic                          push,
    output i2a_pkg::job_t                 push_job,
    input  logic                          q_full
);
    import i2a_pkg::*;

    logic                         fr_valid_reg;
    logic                         fr_valid_next;
    job_t                         fr_job_reg;
    job_t                         job_c;
    logic                         op_ok;
    logic                         accept;
    logic [DEC_MAG_W-1:0]         low32;
    logic [DEC_MAG_W-1:0]         mag32;
    logic                         neg;
    logic [VALUE_W-1:0]           hex_val;
    logic [HEX_DIGITS-1:0][NIB_W-1:0] nib;
    logic [POS_W-1:0]             hex_pos;
    logic [POS_W-1:0]             dec_pos;

    assign in_stall = fr_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = fr_valid_reg && !q_full;
    assign push_job = fr_job_reg;

    assign low32   = value[DEC_MAG_W-1:0];
    assign neg     = (op == OP_SDEC) && low32[DEC_MAG_W-1];
    assign mag32   = neg ? (~low32 + DEC_MAG_W'(1)) : low32;
    assign hex_val = (op == OP_HEX64) ? value : {{(VALUE_W-DEC_MAG_W){1'b0}}, low32};
    assign nib     = hex_val;

    // decimal digit count minus one: how many powers of ten fit
    always_comb
    begin
        dec_pos = '0;
        for (int p = 1; p < DEC_DIGITS; p++)
        begin
            if (DEC_TAB_W'(mag32) >= DEC_TAB[p][1])
            begin
                dec_pos = dec_pos + POS_W'(1);
            end
        end
    end

    // highest nonzero nibble
    always_comb
    begin
        hex_pos = '0;
        for (int i = 0; i < HEX_DIGITS; i++)
        begin
            if (|nib[i])
            begin
                hex_pos = POS_W'(i);
            end
        end
    end

    always_comb
    begin
        op_ok          = 1'b1;
        job_c.is_dec   = 1'b0;
        job_c.upper    = 1'b0;
        job_c.neg      = 1'b0;
        job_c.top_pos  = hex_pos;
        job_c.mag      = hex_val;
        unique case (op)
            OP_SDEC, OP_UDEC:
            begin
                job_c.is_dec  = 1'b1;
                job_c.neg     = neg;
                job_c.top_pos = dec_pos;
                job_c.mag     = {{(VALUE_W-DEC_MAG_W){1'b0}}, mag32};
            end
            OP_HEXL, OP_HEX64:
            begin
                job_c.upper = 1'b0;
            end
            OP_HEXU:
            begin
                job_c.upper = 1'b1;
            end
            default:
            begin
                op_ok = 1'b0;  // drop modes without meaning
            end
        endcase
    end

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        if (accept)
        begin
            fr_valid_next = op_ok;
        end
        else if (push)
        begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fr_job_reg <= job_c;
        end
    end

endmodule

// ===== hw/rtl/i2a_queue.sv =====
// Short job queue between the front end and the character emitter.
`include "integer_to_ascii_formatter_assert.svh"

module i2a_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `I2A_ASSERT_ALWAYS(a_no_push_full, !(push && full), "queue push while full")
    `I2A_ASSERT_ALWAYS(a_no_pop_empty, !(pop && empty), "queue pop while empty")
    `I2A_ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(DEPTH), "queue count out of range")

endmodule

// ===== hw/rtl/i2a_back.sv =====
// Back end: one ASCII character per cycle unless stalled, leading digit first.
`include "integer_to_ascii_formatter_assert.svh"

module i2a_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  i2a_pkg::job_t                 q_job,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [i2a_pkg::CHAR_W-1:0]    char_code,
    output logic                          last_char
);
    import i2a_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE  = 3'b001,
        ST_SIGN  = 3'b010,
        ST_DIGIT = 3'b100
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [VALUE_W-1:0]       rem_reg;
    logic [VALUE_W-1:0]       rem_next;
    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         pos_next;
    logic                     is_dec_reg;
    logic                     is_dec_next;
    logic                     upper_reg;
    logic                     upper_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [CHAR_W-1:0]        char_reg;
    logic [CHAR_W-1:0]        char_next;
    logic                     last_reg;
    logic                     last_next;
    logic                     out_free;
    logic                     load_ok;
    logic [POS_W-1:0]         row_idx;
    logic [DEC_RADIX-1:0][DEC_TAB_W-1:0] row;
    logic [DEC_TAB_W-1:0]     rem_ext;
    logic [DEC_RADIX-1:1]     ge;
    logic [NIB_W-1:0]         dec_digit;
    logic [DEC_TAB_W-1:0]     dec_sub;
    logic                     dec_ovf;
    logic [HEX_DIGITS-1:0][NIB_W-1:0] nib;
    logic [NIB_W-1:0]         cur_digit;

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // decimal digit: compare the remainder against every multiple of 10^pos
    assign row_idx = is_dec_reg ? pos_reg : '0;
    assign row     = DEC_TAB[row_idx];
    assign rem_ext = DEC_TAB_W'(rem_reg[DEC_MAG_W-1:0]);

    always_comb
    begin
        dec_digit = '0;
        for (int k = 1; k < DEC_RADIX; k++)
        begin
            ge[k] = (rem_ext >= row[k]);
            dec_digit = dec_digit + NIB_W'(ge[k]);
        end
    end

    assign dec_sub   = row[dec_digit];
    assign dec_ovf   = ge[DEC_RADIX-1] && ((rem_ext - row[DEC_RADIX-1]) >= row[1]);
    assign nib       = rem_reg;
    assign cur_digit = is_dec_reg ? dec_digit : nib[pos_reg];

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        is_dec_next    = is_dec_reg;
        upper_next     = upper_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        load_ok        = 1'b0;
        pop            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                load_ok = 1'b1;
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CH_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = digit_char(cur_digit, upper_reg);
                    last_next      = (pos_reg == '0);
                    pos_next       = pos_reg - POS_W'(1);
                    if (is_dec_reg)
                    begin
                        rem_next = {{(VALUE_W-DEC_MAG_W){1'b0}},
                                    rem_reg[DEC_MAG_W-1:0] - dec_sub[DEC_MAG_W-1:0]};
                    end
                    if (pos_reg == '0)
                    begin
                        state_next = ST_IDLE;
                        load_ok    = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // take the next job as soon as the current one has emitted its last word
        if (load_ok && !q_empty)
        begin
            pop         = 1'b1;
            state_next  = q_job.neg ? ST_SIGN : ST_DIGIT;
            rem_next    = q_job.mag;
            pos_next    = q_job.top_pos;
            is_dec_next = q_job.is_dec;
            upper_next  = q_job.upper;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        pos_reg    <= pos_next;
        is_dec_reg <= is_dec_next;
        upper_reg  <= upper_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    `I2A_ASSERT_IMPLY(a_char_legal, out_valid_reg,
        (char_reg == CH_MINUS) ||
        ((char_reg >= CH_ZERO) && (char_reg <= CH_NINE)) ||
        ((char_reg >= CH_LO_A) && (char_reg <= CH_LO_F)) ||
        ((char_reg >= CH_UP_A) && (char_reg <= CH_UP_F)),
        "illegal character code")
    `I2A_ASSERT_IMPLY(a_minus_not_last, out_valid_reg && (char_reg == CH_MINUS),
        !last_reg, "minus sign flagged as last character")
    `I2A_ASSERT_IMPLY(a_dec_rem_bound, (state_reg == ST_DIGIT) && is_dec_reg,
        !dec_ovf && (rem_reg[VALUE_W-1:DEC_MAG_W] == '0),
        "decimal remainder exceeds digit position")

endmodule

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: front end, job queue and emitter.
//
// Usage:
//   Input channel (in_valid / in_stall, op, value): one word carries a number
//   and a format mode (signed or unsigned 32-bit decimal, 32-bit hex lower or
//   upper case, 64-bit hex lower case). Words with an unused mode are taken
//   and dropped without output.
//   Output channel (out_valid / out_stall, char_code, last_char): one word per
//   ASCII character, most significant first, no leading zeros, a '-' before a
//   negative signed value, last_char set on the final character.
//   Path: with the block empty, the first character of a number passes the
//   front register, the queue, the emitter registers and the output register.
//   Throughput: one character per cycle from the emitter unless out_stall holds,
//   and a number has 1 to 16 characters (11 for "-2147483648"); the
//   emitter takes the next queued number in the same cycle that it produces
//   the last word of the current one, so numbers follow with no gap.
//   The front end classifies and finds the leading digit ahead of its register;
//   the queue of QUEUE_DEPTH jobs keeps it taking input while the emitter works.
//   Reset (rst_n low, asynchronous) empties the front register, the queue and
//   the output register; no clearing pass is needed.
//   When the receiver holds out_stall, the output word stays; the emitter and
//   then the queue fill, and finally in_stall rises.
module integer_to_ascii_formatter
#(
    parameter int QUEUE_DEPTH = i2a_pkg::QUEUE_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [i2a_pkg::OP_W-1:0]      op,
    input  logic [i2a_pkg::VALUE_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [i2a_pkg::CHAR_W-1:0]    char_code,
    output logic                          last_char
);
    import i2a_pkg::*;

    // front to queue
    logic  push;
    job_t  push_job;
    logic  q_full;

    // queue to emitter
    logic  pop;
    logic  q_empty;
    job_t  q_job;

    // Classify the mode, take the magnitude, find the leading digit position.
    i2a_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .value    (value),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    // Hold classified jobs so the front keeps accepting during long numbers.
    i2a_queue
    #(
        .WIDTH ($bits(job_t)),
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_job),
        .full    (q_full),
        .pop     (pop),
        .rd_data (q_job),
        .empty   (q_empty)
    );

    // Emit sign and digits, one word per cycle unless stalled, into the output register.
    i2a_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (q_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last_char (last_char)
    );

endmodule

// ===== verif/integer_to_ascii_formatter_tb.sv =====
// Self-checking testbench of the integer to ASCII formatter: directed table, random words, idling.
`timescale 1ns / 100ps

module integer_to_ascii_formatter_tb;

    import i2a_pkg::*;

    // Mode codes that carry no format; the block takes and drops such words.
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int DRAIN_CYCLES  = 8;      // margin to catch stray words after the last owed character
    localparam int SHOWN_ERRORS  = 10;
    localparam int PHASES        = 4;
    localparam int WORDS_PER_PHASE = 106;  // about 470 input words in all with table and drops

    // Idle percentages per phase: none, sender only, receiver only, both lightly.
    localparam int SEND_GAP_PCT [PHASES] = '{0, 49, 0, 6};
    localparam int RECV_STALL_PCT [PHASES] = '{0, 0, 49, 6};

    // One output character as the block should present it.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } char_word_t;

    // One row of the directed table. Where golden_known is set, the text is
    // typed in by hand; otherwise the predictor supplies the characters.
    typedef struct {
        logic [OP_W-1:0]    mode;
        logic [VALUE_W-1:0] num;
        bit                 golden_known;
        string              golden;
    } directed_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [OP_W-1:0]     op;
    logic [VALUE_W-1:0]  value;
    logic                out_valid;
    logic                out_stall;
    logic [CHAR_W-1:0]   char_code;
    logic                last_char;

    char_word_t pending_chars[$];   // characters owed by the block, oldest first
    int         error_count;
    int         send_gap_pct;
    int         recv_stall_pct;

    integer_to_ascii_formatter u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last_char (last_char)
    );

    // Free-running clock.
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Hard limit: end the run if it hangs.
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Work out the characters of one number and queue them as expectations.
    // Modes without a format add nothing.
    function automatic void queue_number_chars(input logic [OP_W-1:0] mode,
                                               input logic [VALUE_W-1:0] num);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] d;
        logic [CHAR_W-1:0]  digits [HEX_DIGITS];
        int unsigned        base;
        bit                 caps;
        bit                 minus;
        int                 n;
        mag   = {32'b0, num[31:0]};
        base  = DEC_RADIX;
        caps  = 1'b0;
        minus = 1'b0;
        n     = 0;
        case (mode)
            OP_SDEC:
            begin
                // Negate in 32 bits; the most negative value maps onto itself,
                // which is exactly its magnitude.
                if (num[31])
                begin
                    minus = 1'b1;
                    mag   = {32'b0, -num[31:0]};
                end
            end
            OP_UDEC:  ;
            OP_HEXL:  base = HEX_DIGITS;
            OP_HEXU:
            begin
                base = HEX_DIGITS;
                caps = 1'b1;
            end
            OP_HEX64:
            begin
                base = HEX_DIGITS;
                mag  = num;
            end
            default:  return;
        endcase
        // Peel digits least significant first; zero still yields one digit.
        do
        begin
            d = mag % base;
            if (d < DEC_RADIX)
                digits[n] = CH_ZERO + CHAR_W'(d);
            else
                digits[n] = (caps ? CH_UP_A : CH_LO_A) + CHAR_W'(d - DEC_RADIX);
            mag = mag / base;
            n++;
        end
        while (mag != 0);
        if (minus)
            pending_chars.push_back('{code: CH_MINUS, last: 1'b0});
        for (int k = n - 1; k >= 0; k--)
            pending_chars.push_back('{code: digits[k], last: (k == 0)});
    endfunction

    // Queue hand-typed text as expectations, last character flagged.
    function automatic void queue_golden_text(input string text);
        for (int i = 0; i < text.len(); i++)
            pending_chars.push_back('{code: CHAR_W'(text[i]), last: (i == text.len() - 1)});
    endfunction

    // Draw a value that reaches all digit counts, the sign boundary,
    // decimal carries and zero low halves, mostly with random upper bits.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        logic [31:0]        p;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4, 5, 6:    v = v & ((64'd1 << $urandom_range(1, 64)) - 64'd1);
            7:
            begin
                if ($urandom_range(0, 1))
                    v[31:0] = 32'h8000_0000 + $urandom_range(0, 3);
                else
                    v[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 3);
            end
            8:
            begin
                p = 32'd1;
                repeat ($urandom_range(0, 9)) p = p * DEC_RADIX;
                v[31:0] = p - $urandom_range(0, 1);
            end
            default:
            begin
                v[31:0] = 32'd0;
                if ($urandom_range(0, 1))
                    v = '0;
            end
        endcase
        return v;
    endfunction

    // Present one word from a falling edge, hold it until taken, and return
    // at the next falling edge. Exactly one assignment to in_valid per edge.
    task automatic send_word(input logic [OP_W-1:0] mode, input logic [VALUE_W-1:0] num,
                             input bit golden_known, input string golden);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            // Idle cycle: drop valid and scramble the payload lines.
            in_valid <= 1'b0;
            op       <= OP_W'($urandom);
            value    <= {$urandom, $urandom};
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= mode;
        value    <= num;
        // Hold until a rising edge sees the word taken.
        do
            @(posedge clk);
        while (in_stall);
        if (golden_known)
            queue_golden_text(golden);
        else
            queue_number_chars(mode, num);
        @(negedge clk);
    endtask

    // Receiver: decide stall at the falling edge so it is steady at sampling.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Checker: compare every character taken against the oldest expectation.
    always @(posedge clk)
    begin
        char_word_t exp_word;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                error_count++;
                if (error_count <= SHOWN_ERRORS)
                    $display("unexpected character word: code %h last %b",
                             char_code, last_char);
            end
            else
            begin
                exp_word = pending_chars.pop_front();
                if (char_code !== exp_word.code || last_char !== exp_word.last)
                begin
                    error_count++;
                    if (error_count <= SHOWN_ERRORS)
                        $display("mismatch: expected code %h last %b, got code %h last %b",
                                 exp_word.code, exp_word.last, char_code, last_char);
                end
            end
        end
    end

    // Stimulus: reset, directed table, four idling phases of random words, drain.
    initial
    begin
        directed_row_t table_rows [$];
        logic [OP_W-1:0] mode;
        int              formatted;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        op             = OP_SDEC;
        value          = '0;
        out_stall      = 1'b0;
        error_count    = 0;
        send_gap_pct   = SEND_GAP_PCT[0];
        recv_stall_pct = RECV_STALL_PCT[0];

        // Extremes of each mode, dropped upper halves, and the unused modes.
        table_rows = '{
            '{OP_SDEC,  64'h0,                     1'b1, "0"},
            '{OP_SDEC,  64'h0000_0000_7FFF_FFFF,   1'b1, "2147483647"},
            '{OP_SDEC,  64'h0000_0000_8000_0000,   1'b1, "-2147483648"},
            '{OP_SDEC,  64'h0000_0000_FFFF_FFFF,   1'b1, "-1"},
            '{OP_SDEC,  64'hFFFF_FFFF_0000_0005,   1'b1, "5"},
            '{OP_SDEC,  64'h0000_0000_8000_0001,   1'b0, ""},
            '{OP_SDEC,  64'd12345,                 1'b0, ""},
            '{OP_UDEC,  64'h0,                     1'b1, "0"},
            '{OP_UDEC,  64'h0000_0000_FFFF_FFFF,   1'b1, "4294967295"},
            '{OP_UDEC,  64'hDEAD_BEEF_0000_000A,   1'b1, "10"},
            '{OP_UDEC,  64'd1000000000,            1'b0, ""},
            '{OP_HEXL,  64'h0,                     1'b1, "0"},
            '{OP_HEXL,  64'h0000_0000_FFFF_FFFF,   1'b1, "ffffffff"},
            '{OP_HEXL,  64'h1234_5678_9ABC_DEF0,   1'b1, "9abcdef0"},
            '{OP_HEXU,  64'h0000_0000_FFFF_FFFF,   1'b1, "FFFFFFFF"},
            '{OP_HEXU,  64'hFFFF_FFFF_0000_ABCD,   1'b1, "ABCD"},
            '{OP_HEXU,  64'h5,                     1'b0, ""},
            '{OP_HEX64, 64'h0,                     1'b1, "0"},
            '{OP_HEX64, 64'hFFFF_FFFF_FFFF_FFFF,   1'b1, "ffffffffffffffff"},
            '{OP_HEX64, 64'h0123_4567_89AB_CDEF,   1'b1, "123456789abcdef"},
            '{OP_HEX64, 64'h8000_0000_0000_0000,   1'b0, ""},
            '{OP_RSVD5, 64'h0000_0000_0000_0001,   1'b1, ""},
            '{OP_RSVD6, 64'hFFFF_FFFF_FFFF_FFFF,   1'b1, ""},
            '{OP_RSVD7, 64'h0000_0000_8000_0000,   1'b1, ""}
        };

        // Hold reset, then release it at a falling edge.
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows run with no idling on either side.
        foreach (table_rows[i])
            send_word(table_rows[i].mode, table_rows[i].num,
                      table_rows[i].golden_known, table_rows[i].golden);

        // Random words; the knobs change only between words, never mid-handshake.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            send_gap_pct   = SEND_GAP_PCT[ph];
            recv_stall_pct = RECV_STALL_PCT[ph];
            formatted = 0;
            while (formatted < WORDS_PER_PHASE)
            begin
                // About one word in twenty carries an unused mode; those
                // produce nothing and do not count toward the phase.
                if ($urandom_range(0, 19) == 0)
                    mode = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
                else
                begin
                    mode = OP_W'($urandom_range(OP_SDEC, OP_HEX64));
                    formatted++;
                end
                send_word(mode, pick_value(), 1'b0, "");
            end
        end
        in_valid <= 1'b0;

        // Drain: wait for every owed character, then watch for strays.
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_chars.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
